/* hw/rtl/xnc_pkg.sv */
// ----------------------------------------------------------------------------
// xnc_pkg
// Shared types and codes for the nesting checker: symbol kinds, local
// classes, stack entry layout and the stack command word.
// ----------------------------------------------------------------------------
package xnc_pkg;

  localparam int TAG_W       = 4;
  localparam int MODE_W      = 2;
  localparam int CLS_W       = 3;
  localparam int CFG_W       = 5;
  localparam int OUT_DEPTH_W = 7;
  localparam int MAX_TAGS_C  = 16;
  localparam int MAX_DEPTH_C = 64;

  // symbol kind; the fourth code has no transition
  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN  = 2'd0,
    MODE_LOCAL = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_t;

  localparam logic [CLS_W-1:0] CLS_LETTER = 3'd0;
  localparam logic [CLS_W-1:0] CLS_SPACE  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_EQUALS = 3'd2;
  localparam logic [CLS_W-1:0] CLS_QUOTE  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_BODY   = 3'd4;

  typedef struct packed {
    logic             nested;
    logic [TAG_W-1:0] tag;
  } stk_entry_t;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic       pop;
    stk_entry_t entry;
  } stk_op_t;

  typedef struct packed {
    logic accepted;
    logic rejected;
    logic overflow;
  } xnc_res_t;

endpackage

/* hw/rtl/xnc_stack.sv */
// ----------------------------------------------------------------------------
// xnc_stack
// Open-tag stack. The top entry lives in a register; the rest lives in a
// synchronous memory. The entry below the top is prefetched every cycle so a
// pop takes the prefetched entry as top, with push writes forwarded into it.
// ----------------------------------------------------------------------------
module xnc_stack #(
  parameter  int MAX_DEPTH = xnc_pkg::MAX_DEPTH_C,
  localparam int AW        = $clog2(MAX_DEPTH),
  localparam int DW        = $clog2(MAX_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  xnc_pkg::stk_op_t    op,
  output logic [DW-1:0]       depth,
  output logic [DW-1:0]       depth_nxt,
  output xnc_pkg::stk_entry_t tos
);
  import xnc_pkg::*;

  stk_entry_t mem [MAX_DEPTH];

  logic [DW-1:0] depth_r;
  logic [DW-1:0] base;
  stk_entry_t    tos_r;
  stk_entry_t    tos_nxt;
  stk_entry_t    below_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  always_comb begin
    base      = op.clear ? '0 : depth_r;
    depth_nxt = base;
    tos_nxt   = tos_r;
    if (op.push) begin
      depth_nxt = base + DW'(1);
      tos_nxt   = op.entry;
    end else if (op.pop) begin
      depth_nxt = base - DW'(1);
      tos_nxt   = below_r;
    end
    // spill the old top below the new one
    we    = op.push && (base != '0);
    waddr = AW'(base - DW'(1));
    raddr = (depth_nxt >= DW'(2)) ? AW'(depth_nxt - DW'(2)) : '0;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= tos_r;
    end
    // forward the spill when it lands on the prefetched slot
    if (we && (waddr == raddr)) begin
      below_r <= tos_r;
    end else begin
      below_r <= mem[raddr];
    end
    tos_r <= tos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  assign depth = depth_r;
  assign tos   = tos_r;

endmodule

/* hw/rtl/xnc_ctrl.sv */
// ----------------------------------------------------------------------------
// xnc_ctrl
// Control machine of the recognizer: steps the 17-state machine, decides
// push and pop, and keeps the sticky reject and overflow flags and the
// tag-count register.
// ----------------------------------------------------------------------------
module xnc_ctrl #(
  parameter  int MAX_DEPTH = xnc_pkg::MAX_DEPTH_C,
  localparam int DW        = $clog2(MAX_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [xnc_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         go,
  input  logic                         start_word,
  input  logic [xnc_pkg::MODE_W-1:0]   mode,
  input  logic [xnc_pkg::TAG_W-1:0]    tag,
  input  logic [xnc_pkg::CLS_W-1:0]    local_class,
  input  logic [DW-1:0]                depth,
  input  xnc_pkg::stk_entry_t          tos,
  output xnc_pkg::stk_op_t             op,
  output xnc_pkg::xnc_res_t            res
);
  import xnc_pkg::*;

  typedef enum logic [4:0] {
    ST_INITIAL,
    ST_ROOT_OPENED,
    ST_ROOT_ATTR_NAME,
    ST_ROOT_AFTER_EQ,
    ST_ROOT_ATTR_VAL,
    ST_ROOT_AFTER_ATTR,
    ST_ROOT_BODY,
    ST_ROOT_TEXT,
    ST_NEST_OPENED,
    ST_NEST_ATTR_NAME,
    ST_NEST_AFTER_EQ,
    ST_NEST_ATTR_VAL,
    ST_NEST_AFTER_ATTR,
    ST_NEST_BODY,
    ST_NEST_TEXT,
    ST_CHILD_DONE,
    ST_ROOT_DONE
  } state_t;

  typedef struct packed {
    logic   move;
    state_t nxt;
  } lmove_t;

  function automatic lmove_t local_step(input state_t s, input logic [CLS_W-1:0] c);
    lmove_t r;
    r.move = 1'b0;
    r.nxt  = s;
    case (s)
      ST_ROOT_OPENED, ST_ROOT_AFTER_ATTR: begin
        if (c == CLS_SPACE) begin
          r = '{1'b1, ST_ROOT_ATTR_NAME};
        end else if (c == CLS_BODY) begin
          r = '{1'b1, ST_ROOT_BODY};
        end
      end
      ST_ROOT_ATTR_NAME: begin
        if (c == CLS_LETTER) begin
          r = '{1'b1, ST_ROOT_ATTR_NAME};
        end else if (c == CLS_EQUALS) begin
          r = '{1'b1, ST_ROOT_AFTER_EQ};
        end
      end
      ST_ROOT_AFTER_EQ: begin
        if (c == CLS_QUOTE) r = '{1'b1, ST_ROOT_ATTR_VAL};
      end
      ST_ROOT_ATTR_VAL: begin
        if (c == CLS_LETTER) begin
          r = '{1'b1, ST_ROOT_ATTR_VAL};
        end else if (c == CLS_QUOTE) begin
          r = '{1'b1, ST_ROOT_AFTER_ATTR};
        end
      end
      ST_ROOT_BODY, ST_ROOT_TEXT: begin
        if (c == CLS_LETTER) r = '{1'b1, ST_ROOT_TEXT};
      end
      ST_NEST_OPENED, ST_NEST_AFTER_ATTR: begin
        if (c == CLS_SPACE) begin
          r = '{1'b1, ST_NEST_ATTR_NAME};
        end else if (c == CLS_BODY) begin
          r = '{1'b1, ST_NEST_BODY};
        end
      end
      ST_NEST_ATTR_NAME: begin
        if (c == CLS_LETTER) begin
          r = '{1'b1, ST_NEST_ATTR_NAME};
        end else if (c == CLS_EQUALS) begin
          r = '{1'b1, ST_NEST_AFTER_EQ};
        end
      end
      ST_NEST_AFTER_EQ: begin
        if (c == CLS_QUOTE) r = '{1'b1, ST_NEST_ATTR_VAL};
      end
      ST_NEST_ATTR_VAL: begin
        if (c == CLS_LETTER) begin
          r = '{1'b1, ST_NEST_ATTR_VAL};
        end else if (c == CLS_QUOTE) begin
          r = '{1'b1, ST_NEST_AFTER_ATTR};
        end
      end
      ST_NEST_BODY, ST_NEST_TEXT: begin
        if (c == CLS_LETTER) r = '{1'b1, ST_NEST_TEXT};
      end
      default: begin
        r.move = 1'b0;
      end
    endcase
    return r;
  endfunction

  state_t           state_r, state_nxt, state_eff;
  logic             reject_r, reject_nxt, reject_eff;
  logic             ovf_r, ovf_nxt, ovf_eff;
  logic [CFG_W-1:0] num_tags_r;
  logic [DW-1:0]    depth_eff;
  logic             tag_ok;
  logic             ok;
  logic             push, pop, nested;
  lmove_t           lm;

  always_comb begin
    state_eff  = start_word ? ST_INITIAL : state_r;
    reject_eff = start_word ? 1'b0 : reject_r;
    ovf_eff    = start_word ? 1'b0 : ovf_r;
    depth_eff  = start_word ? '0 : depth;
    tag_ok     = ({1'b0, tag} < num_tags_r) && (int'(tag) < MAX_TAGS_C);
    lm         = local_step(state_eff, local_class);
    state_nxt  = state_eff;
    ovf_nxt    = ovf_eff;
    ok         = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    nested     = 1'b0;
    if (!reject_eff) begin
      case (mode)
        MODE_OPEN: begin
          if (tag_ok && (state_eff == ST_INITIAL || state_eff == ST_ROOT_BODY ||
                         state_eff == ST_NEST_BODY)) begin
            nested = (state_eff != ST_INITIAL);
            if (depth_eff == DW'(MAX_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              ok        = 1'b1;
              push      = 1'b1;
              state_nxt = nested ? ST_NEST_OPENED : ST_ROOT_OPENED;
            end
          end
        end
        MODE_LOCAL: begin
          if (lm.move) begin
            ok        = 1'b1;
            state_nxt = lm.nxt;
          end
        end
        MODE_CLOSE: begin
          if (tag_ok && (depth_eff != '0) && (tos.tag == tag)) begin
            if (state_eff == ST_CHILD_DONE) begin
              ok        = 1'b1;
              state_nxt = tos.nested ? ST_CHILD_DONE : ST_ROOT_DONE;
            end else if (!tos.nested && (state_eff == ST_ROOT_OPENED ||
                                         state_eff == ST_ROOT_TEXT)) begin
              ok        = 1'b1;
              state_nxt = ST_ROOT_DONE;
            end else if (tos.nested && (state_eff == ST_NEST_OPENED ||
                                        state_eff == ST_NEST_TEXT)) begin
              ok        = 1'b1;
              state_nxt = ST_CHILD_DONE;
            end
            pop = ok;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
    reject_nxt = reject_eff | ~ok;

    op.clear        = go & start_word;
    op.push         = go & push;
    op.pop          = go & pop;
    op.entry.nested = nested;
    op.entry.tag    = tag;

    res.accepted = (state_nxt == ST_ROOT_DONE) && !reject_nxt;
    res.rejected = reject_nxt;
    res.overflow = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INITIAL;
      reject_r   <= 1'b0;
      ovf_r      <= 1'b0;
      num_tags_r <= CFG_W'(1);
    end else begin
      if (go) begin
        state_r  <= state_nxt;
        reject_r <= reject_nxt;
        ovf_r    <= ovf_nxt;
      end
      if (cfg_wr_en) begin
        num_tags_r <= cfg_wr_data;
      end
    end
  end

endmodule

/* hw/rtl/xml_nesting_checker_unit.sv */
// ----------------------------------------------------------------------------
// xml_nesting_checker_unit
// Nesting recognizer for a simplified XML shape over classified symbols.
// ----------------------------------------------------------------------------
// Input channel (in_*): one classified symbol per word: start_word, mode
// (open, local, close), tag and local class. Result channel (out_*): one
// word per input word with accepted, rejected, overflow and stack depth.
// Both channels use valid/stall; cfg_wr_en/cfg_wr_data write num_tags.
// The result sits in the output register on the cycle after the symbol is
// taken. Throughput is one symbol per cycle while no stall is raised; the top
// stack entry is kept in a register and the entry below it is prefetched
// from the synchronous stack memory every cycle, so pops and pushes run back
// to back. While out_stall holds a waiting result, in_stall is raised and
// the result is held. Reset clears the machine, flags, depth and output
// valid and sets num_tags to 1; the stack memory is not cleared, since only
// entries pushed since the last start are read.
// ----------------------------------------------------------------------------
module xml_nesting_checker_unit #(
  parameter  int MAX_DEPTH = xnc_pkg::MAX_DEPTH_C,
  localparam int DW        = $clog2(MAX_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [xnc_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_start_word,
  input  logic [xnc_pkg::MODE_W-1:0]        in_mode,
  input  logic [xnc_pkg::TAG_W-1:0]         in_tag,
  input  logic [xnc_pkg::CLS_W-1:0]         in_local_class,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic                              out_rejected,
  output logic                              out_overflow,
  output logic [xnc_pkg::OUT_DEPTH_W-1:0]   out_depth
);
  import xnc_pkg::*;

  logic                       go;
  stk_op_t                    op;
  xnc_res_t                   res;
  stk_entry_t                 tos;
  logic [DW-1:0]              stk_depth;
  logic [DW-1:0]              stk_depth_nxt;
  logic [DW+OUT_DEPTH_W-1:0]  depth_ext;
  logic                       out_valid_r;
  xnc_res_t                   res_r;
  logic [OUT_DEPTH_W-1:0]     depth_r;

  assign in_stall  = out_valid_r & out_stall;
  assign go        = in_valid & ~in_stall;
  assign depth_ext = {{OUT_DEPTH_W{1'b0}}, stk_depth_nxt};

  xnc_ctrl #(.MAX_DEPTH(MAX_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .start_word  (in_start_word),
    .mode        (in_mode),
    .tag         (in_tag),
    .local_class (in_local_class),
    .depth       (stk_depth),
    .tos         (tos),
    .op          (op),
    .res         (res)
  );

  xnc_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .depth     (stk_depth),
    .depth_nxt (stk_depth_nxt),
    .tos       (tos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r   <= res;
      depth_r <= depth_ext[OUT_DEPTH_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = res_r.accepted;
  assign out_rejected = res_r.rejected;
  assign out_overflow = res_r.overflow;
  assign out_depth    = depth_r;

`ifndef SYNTHESIS
  a_ovf_rejects : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_rejected)
    else $error("overflow reported without reject");

  a_depth_bound : assert property (@(posedge clk) disable iff (!rst_n)
    stk_depth <= DW'(MAX_DEPTH))
    else $error("stack depth beyond capacity");

  a_reject_freezes : assert property (@(posedge clk) disable iff (!rst_n)
    go && out_valid && out_rejected && !in_start_word |=>
      out_rejected && (stk_depth == $past(stk_depth)))
    else $error("stack moved after reject");
`endif

endmodule
